FILE: hdl/rwt_pkg.sv
package rwt_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // fixed-point widths
  localparam int unsigned PCT_W  = 15;
  localparam int unsigned EASE_W = 9;
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned P_W    = 26;  // signed delta * ease product

  localparam logic [PCT_W-1:0] FULL_PCT = 15'd25600;

  localparam int unsigned DRY_REF_RST = 3500;
  localparam int unsigned WET_REF_RST = 1500;

  // floor(x / 300) = (x * REC300) >> SH300 for x < 2^16
  localparam logic [16:0] REC300 = 17'd111849;
  localparam int unsigned SH300  = 25;
  // floor(x / 200) = (x * REC200) >> SH200 for x < 2^16
  localparam logic [16:0] REC200 = 17'd83887;
  localparam int unsigned SH200  = 24;
  localparam int unsigned REC_W  = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_THRESH  = 3'd0,
    CFG_MIN_SPAN     = 3'd1,
    CFG_EASE_WET     = 3'd2,
    CFG_EASE_DRY     = 3'd3,
    CFG_WET_DEBOUNCE = 3'd4,
    CFG_DRY_DEBOUNCE = 3'd5,
    CFG_MIN_WET_HOLD = 3'd6,
    CFG_MIN_DRY_HOLD = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]  drop_thresh;
    logic [CFG_W-1:0]  min_span;
    logic [EASE_W-1:0] ease_wet;
    logic [EASE_W-1:0] ease_dry;
    logic [MS_W-1:0]   wet_settle_ms;
    logic [MS_W-1:0]   dry_settle_ms;
    logic [MS_W-1:0]   min_wet_hold_ms;
    logic [MS_W-1:0]   min_dry_hold_ms;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    drop_thresh:     12'd200,
    min_span:        12'd100,
    ease_wet:        9'd64,
    ease_dry:        9'd16,
    wet_settle_ms:   16'd1000,
    dry_settle_ms:   16'd5000,
    min_wet_hold_ms: 16'd10000,
    min_dry_hold_ms: 16'd10000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_REFS,
    ST_SPAN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EASE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic judge;
    logic refs;
    logic span;
    logic div_start;
    logic ease;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

FILE: hdl/rwt_if.sv
interface rwt_in_if #(
  parameter int unsigned SAMPLE_BITS = rwt_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [SAMPLE_BITS-1:0]      sample;
  logic                        hw_wet;
  logic [rwt_pkg::TIME_W-1:0]  time_ms;

  modport source (output valid, sample, hw_wet, time_ms, input ready);
  modport sink   (input valid, sample, hw_wet, time_ms, output ready);
endinterface

interface rwt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       wet_now;
  logic [rwt_pkg::PCT_W-1:0]  wetness_pct;
  logic                       servo_wet;
  logic                       servo_moved;

  modport source (output valid, wet_now, wetness_pct, servo_wet, servo_moved, input ready);
  modport sink   (input valid, wet_now, wetness_pct, servo_wet, servo_moved, output ready);
endinterface

interface rwt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rwt_pkg::CFG_IDX_W-1:0]   index;
  logic [rwt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rwt_cfg.sv
module rwt_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  rwt_cfg_if.sink       cfg_i,
  output rwt_pkg::cfg_t cfg_o
);
  import rwt_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DROP_THRESH:  cfg_q.drop_thresh     <= cfg_i.data[CFG_W-1:0];
        CFG_MIN_SPAN:     cfg_q.min_span        <= cfg_i.data[CFG_W-1:0];
        CFG_EASE_WET:     cfg_q.ease_wet        <= cfg_i.data[EASE_W-1:0];
        CFG_EASE_DRY:     cfg_q.ease_dry        <= cfg_i.data[EASE_W-1:0];
        CFG_WET_DEBOUNCE: cfg_q.wet_settle_ms   <= cfg_i.data[MS_W-1:0];
        CFG_DRY_DEBOUNCE: cfg_q.dry_settle_ms   <= cfg_i.data[MS_W-1:0];
        CFG_MIN_WET_HOLD: cfg_q.min_wet_hold_ms <= cfg_i.data[MS_W-1:0];
        CFG_MIN_DRY_HOLD: cfg_q.min_dry_hold_ms <= cfg_i.data[MS_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

endmodule

FILE: hdl/rwt_div.sv
module rwt_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 12,
  parameter int unsigned QUO_W = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic             ovf_o,
  output logic [QUO_W-1:0] quo_o
);
  localparam int unsigned IW    = DEN_W + QUO_W;
  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic [IW-1:0]    rem_q, dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q, ovf_q;

  logic [IW-1:0] num_ext;
  logic          ovf_c;
  logic          ge_c;

  assign num_ext = IW'(num_i);
  // quotient would not fit in QUO_W bits
  assign ovf_c   = (num_ext >> QUO_W) >= IW'(den_i);
  assign ge_c    = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (ovf_c) begin
          done_q <= 1'b1;
          run_q  <= 1'b0;
        end else begin
          run_q <= 1'b1;
          cnt_q <= CNT_W'(QUO_W - 1);
        end
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= ovf_c;
      rem_q <= num_ext;
      dsh_q <= IW'(den_i) << (QUO_W - 1);
      quo_q <= '0;
    end else if (run_q) begin
      if (ge_c) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge_c};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/rwt_ctrl.sv
module rwt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rwt_pkg::cmd_t cmd_o,
  input  rwt_pkg::sts_t sts_i
);
  import rwt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = ST_REFS;
      end
      ST_REFS: begin
        cmd_o.refs = 1'b1;
        state_d    = ST_SPAN;
      end
      ST_SPAN: begin
        cmd_o.span = 1'b1;
        state_d    = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_EASE;
        end
      end
      ST_EASE: begin
        cmd_o.ease = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // commit only when the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/rwt_dp.sv
module rwt_dp #(
  parameter int unsigned SAMPLE_BITS = rwt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rwt_pkg::cmd_t               cmd_i,
  output rwt_pkg::sts_t               sts_o,
  input  rwt_pkg::cfg_t               cfg_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic                        hw_wet_i,
  input  logic [rwt_pkg::TIME_W-1:0]  time_ms_i,
  output logic                        wet_now_o,
  output logic [rwt_pkg::PCT_W-1:0]   wetness_pct_o,
  output logic                        servo_wet_o,
  output logic                        servo_moved_o
);
  import rwt_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned SPAN_W = (SB > CFG_W) ? SB : CFG_W;
  localparam int unsigned NUM_W  = SB + PCT_W;
  localparam int unsigned MUL_W  = SB + REC_W;
  localparam logic [SB-1:0] DRY_RST = SB'(DRY_REF_RST);
  localparam logic [SB-1:0] WET_RST = SB'(WET_REF_RST);
  localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(128);

  // captured item
  logic [SB-1:0]     raw_q;
  logic              hw_q;
  logic [TIME_W-1:0] now_q;
  // judge stage
  logic              wet_q, gap_neg_q, rise_q;
  logic [MUL_W-1:0]  prod300_q, prod200_q;
  // tracked state
  logic [SB-1:0]     dry_ref_q, wet_ref_q;
  logic [PCT_W-1:0]  shown_q;
  logic [TIME_W-1:0] wet_since_q, dry_since_q, last_move_q;
  logic              wsv_q, dsv_q, at_wet_q;
  // percentage path
  logic [SPAN_W-1:0] span_q;
  logic [NUM_W-1:0]  num_q;
  logic signed [P_W-1:0] p_q;
  // result
  logic              res_wet_q, res_moved_q;

  // judge
  logic [SPAN_W:0] sum_td_c;
  logic            wet_c, rise_c;
  logic [SB:0]     gap_c;
  logic [SB-1:0]   gap_abs_c, diff_up_c;

  assign sum_td_c  = (SPAN_W+1)'(raw_q) + (SPAN_W+1)'(cfg_i.drop_thresh);
  assign wet_c     = hw_q || (sum_td_c < (SPAN_W+1)'(dry_ref_q));
  assign gap_c     = {1'b0, dry_ref_q} - {1'b0, wet_ref_q};
  assign gap_abs_c = gap_c[SB] ? SB'(~gap_c + 1'b1) : gap_c[SB-1:0];
  assign rise_c    = !wet_c && (raw_q > dry_ref_q);
  assign diff_up_c = raw_q - dry_ref_q;

  // refs
  logic [SB-1:0] q300_c, q200_c;

  assign q300_c = SB'(prod300_q >> SH300);
  assign q200_c = SB'(prod200_q >> SH200);

  // span and numerator from the updated refs
  logic [SB:0]       sd_c;
  logic [SPAN_W-1:0] span_a_c, span_m_c, span_b_c;
  logic [SB-1:0]     drop_c;

  assign sd_c     = {1'b0, dry_ref_q} - {1'b0, wet_ref_q};
  assign span_a_c = sd_c[SB] ? '0 : SPAN_W'(sd_c[SB-1:0]);
  assign span_m_c = SPAN_W'(cfg_i.min_span);
  assign span_b_c = (span_a_c > span_m_c) ? span_a_c : span_m_c;
  assign drop_c   = (raw_q < dry_ref_q) ? (dry_ref_q - raw_q) : '0;

  // divider
  logic             div_done, div_ovf;
  logic [PCT_W-1:0] div_quo;

  rwt_div #(
    .NUM_W (NUM_W),
    .DEN_W (SPAN_W),
    .QUO_W (PCT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (span_q),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .quo_o   (div_quo)
  );

  assign sts_o.div_done = div_done;

  // ease
  logic [PCT_W-1:0]        target_c;
  logic signed [PCT_W:0]   delta_c;
  logic [EASE_W-1:0]       ease_c;
  logic signed [EASE_W:0]  ease_s_c;
  logic signed [P_W-1:0]   p_c;

  assign target_c = (div_ovf || (div_quo > FULL_PCT)) ? FULL_PCT : div_quo;
  assign delta_c  = $signed({1'b0, target_c}) - $signed({1'b0, shown_q});
  assign ease_c   = wet_q ? cfg_i.ease_wet : cfg_i.ease_dry;
  assign ease_s_c = $signed({1'b0, ease_c});
  assign p_c      = P_W'(delta_c) * P_W'(ease_s_c);

  // final: level update and actuator
  logic signed [P_W-1:0] step_c, lvl_c;
  logic [PCT_W-1:0]      shown_c;
  logic [TIME_W-1:0]     wet_since_c, dry_since_c, dwell_c;
  logic                  req_wet_c, req_dry_c, go_wet_c, go_dry_c, moved_c;

  assign step_c  = (p_q + ROUND_HALF) >>> 8;
  assign lvl_c   = P_W'($signed({1'b0, shown_q})) + step_c;
  assign shown_c = (lvl_c < 0) ? '0 :
                   (lvl_c > P_W'($signed({1'b0, FULL_PCT}))) ? FULL_PCT :
                   lvl_c[PCT_W-1:0];

  // an episode opens on the first step of its kind
  assign wet_since_c = (wet_q && !wsv_q) ? now_q : wet_since_q;
  assign dry_since_c = (!wet_q && !dsv_q) ? now_q : dry_since_q;
  assign req_wet_c   = wet_q && ((now_q - wet_since_c) >= TIME_W'(cfg_i.wet_settle_ms));
  assign req_dry_c   = !wet_q && ((now_q - dry_since_c) >= TIME_W'(cfg_i.dry_settle_ms));
  assign dwell_c     = now_q - last_move_q;
  assign go_wet_c    = !at_wet_q && req_wet_c && (dwell_c >= TIME_W'(cfg_i.min_dry_hold_ms));
  assign go_dry_c    = at_wet_q && req_dry_c && (dwell_c >= TIME_W'(cfg_i.min_wet_hold_ms));
  assign moved_c     = go_wet_c || go_dry_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_ref_q   <= DRY_RST;
      wet_ref_q   <= WET_RST;
      shown_q     <= '0;
      wet_since_q <= '0;
      dry_since_q <= '0;
      last_move_q <= '0;
      wsv_q       <= 1'b0;
      dsv_q       <= 1'b0;
      at_wet_q    <= 1'b0;
      res_wet_q   <= 1'b0;
      res_moved_q <= 1'b0;
    end else begin
      if (cmd_i.refs) begin
        if (wet_q) begin
          if (raw_q < wet_ref_q) begin
            wet_ref_q <= raw_q;
          end
        end else begin
          wet_ref_q <= gap_neg_q ? (wet_ref_q - q300_c) : (wet_ref_q + q300_c);
        end
        if (rise_q) begin
          dry_ref_q <= dry_ref_q + q200_c;
        end
      end
      if (cmd_i.fin) begin
        shown_q     <= shown_c;
        wet_since_q <= wet_since_c;
        dry_since_q <= dry_since_c;
        wsv_q       <= wet_q;
        dsv_q       <= !wet_q;
        at_wet_q    <= at_wet_q ^ moved_c;
        if (moved_c) begin
          last_move_q <= now_q;
        end
        res_wet_q   <= wet_q;
        res_moved_q <= moved_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q <= sample_i;
      hw_q  <= hw_wet_i;
      now_q <= time_ms_i;
    end
    if (cmd_i.judge) begin
      wet_q     <= wet_c;
      gap_neg_q <= gap_c[SB];
      rise_q    <= rise_c;
      prod300_q <= MUL_W'(gap_abs_c) * MUL_W'(REC300);
      prod200_q <= MUL_W'(diff_up_c) * MUL_W'(REC200);
    end
    if (cmd_i.span) begin
      span_q <= (span_b_c == '0) ? SPAN_W'(1) : span_b_c;
      num_q  <= NUM_W'(drop_c) * NUM_W'(FULL_PCT);
    end
    if (cmd_i.ease) begin
      p_q <= p_c;
    end
  end

  assign wet_now_o     = res_wet_q;
  assign wetness_pct_o = shown_q;
  assign servo_wet_o   = at_wet_q;
  assign servo_moved_o = res_moved_q;

endmodule

FILE: hdl/rain_wetness_tracker_core.sv
// Rain plate wetness tracker.
// in_i  : one beat per plate reading (sample, hw_wet, time_ms), valid/ready.
// out_o : one beat per input beat (wet_now, wetness_pct Q7.8, servo_wet,
//         servo_moved), valid/ready, in input order.
// cfg_i : register writes (index, data), always ready; write only while idle.
// Each item runs through judge, reference update, span/numerator, a
// 15-step shift-subtract divider for the percentage, easing and the
// actuator update. When the quotient would not fit in 15 bits the divider
// skips its steps and the level target saturates. in_i.ready rises together
// with out_o.valid, so an item is only taken once the previous one is done.
// The result sits in an output register; a new item is taken while it waits.
// If out_o stalls, the next item runs up to its final step and holds there
// until the waiting beat is taken.
// Reset clears all tracked state to its power-up values (dry ref 3500,
// wet ref 1500, level 0, actuator at dry) and reloads register defaults.
module rain_wetness_tracker_core #(
  parameter int unsigned SAMPLE_BITS = rwt_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rwt_in_if.sink    in_i,
  rwt_out_if.source out_o,
  rwt_cfg_if.sink   cfg_i
);
  import rwt_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rwt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rwt_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .sample_i      (in_i.sample),
    .hw_wet_i      (in_i.hw_wet),
    .time_ms_i     (in_i.time_ms),
    .wet_now_o     (out_o.wet_now),
    .wetness_pct_o (out_o.wetness_pct),
    .servo_wet_o   (out_o.servo_wet),
    .servo_moved_o (out_o.servo_moved)
  );

  // one item in flight: busy right after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.wetness_pct <= FULL_PCT))
    else $error("wetness level above full scale");

  // a wet step can only move the actuator to wet, a dry step only to dry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.servo_moved) |-> (out_o.servo_wet == out_o.wet_now))
    else $error("actuator moved against the current condition");

endmodule
